>>> hdl/pcm_frame_format_converter_assert.svh
// Assertion macros for the PCM frame format converter.
`ifndef PCM_FRAME_FORMAT_CONVERTER_ASSERT_SVH
`define PCM_FRAME_FORMAT_CONVERTER_ASSERT_SVH

// Check that a holds the same cycle as b.
`define PFC_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pfc assertion failed");

// Check that b holds the cycle after a.
`define PFC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pfc assertion failed");

`endif

>>> hdl/pfc_pkg.sv
// Shared types, register indexes and arithmetic helpers for the PCM format converter.
package pfc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_16BIT   = 2'd0,
        CFG_IN_STEREO  = 2'd1,
        CFG_OUT_16BIT  = 2'd2,
        CFG_OUT_STEREO = 2'd3
    } pfc_cfg_idx_t;

    typedef struct packed {
        logic in_is_16bit;
        logic in_is_stereo;
        logic out_is_16bit;
        logic out_is_stereo;
    } pfc_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } pfc_frame_t;

    // Divide by 256, truncating toward zero.
    function automatic logic signed [SAMPLE_W-1:0] div256(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-1:0] biased;
        biased = s + (s[SAMPLE_W-1] ? 16'sd255 : 16'sd0);
        return biased >>> 8;
    endfunction

    // Divide by 2, truncating toward zero.
    function automatic logic signed [SAMPLE_W-1:0] half(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-1:0] biased;
        biased = s + (s[SAMPLE_W-1] ? 16'sd1 : 16'sd0);
        return biased >>> 1;
    endfunction

endpackage

>>> hdl/pfc_cfg_regs.sv
// Configuration register file for the PCM format converter.
module pfc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    output pfc_pkg::pfc_cfg_t             cfg
);
    import pfc_pkg::*;

    pfc_cfg_t cfg_reg;
    pfc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (pfc_cfg_idx_t'(cfg_index))
                CFG_IN_16BIT:   cfg_next.in_is_16bit   = cfg_data;
                CFG_IN_STEREO:  cfg_next.in_is_stereo  = cfg_data;
                CFG_OUT_16BIT:  cfg_next.out_is_16bit  = cfg_data;
                CFG_OUT_STEREO: cfg_next.out_is_stereo = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{in_is_16bit: 1'b1, in_is_stereo: 1'b1,
                         out_is_16bit: 1'b1, out_is_stereo: 1'b1};
        else
            cfg_reg <= cfg_next;
    end

endmodule

>>> hdl/pfc_convert.sv
// Combinational width and channel conversion of one frame.
module pfc_convert (
    input  pfc_pkg::pfc_cfg_t   cfg,
    input  pfc_pkg::pfc_frame_t frame_in,
    output pfc_pkg::pfc_frame_t frame_out
);
    import pfc_pkg::*;

    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] lw;
    logic signed [SAMPLE_W-1:0] rw;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W:0]   sum_biased;
    logic signed [SAMPLE_W:0]   sum_div;
    logic signed [SAMPLE_W-1:0] mix;

    always_comb
    begin
        if (cfg.in_is_16bit)
        begin
            l = frame_in.left;
            r = frame_in.right;
        end
        else
        begin
            l = {{8{frame_in.left[7]}}, frame_in.left[7:0]};
            r = {{8{frame_in.right[7]}}, frame_in.right[7:0]};
        end

        if (cfg.in_is_16bit == cfg.out_is_16bit)
        begin
            lw = l;
            rw = r;
        end
        else if (cfg.out_is_16bit)
        begin
            lw = {l[7:0], 8'h00};
            rw = {r[7:0], 8'h00};
        end
        else
        begin
            lw = div256(l);
            rw = div256(r);
        end

        sum        = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
        sum_biased = sum + (sum[SAMPLE_W] ? 17'sd511 : 17'sd0);
        sum_div    = sum_biased >>> 9;

        if (cfg.in_is_16bit == cfg.out_is_16bit)
            mix = half(l) + half(r);
        else if (cfg.out_is_16bit)
            mix = {sum[8:0], 7'b0};
        else
            mix = sum_div[SAMPLE_W-1:0];

        frame_out.last = frame_in.last;
        if (!cfg.in_is_stereo)
        begin
            frame_out.left  = lw;
            frame_out.right = cfg.out_is_stereo ? lw : '0;
        end
        else if (cfg.out_is_stereo)
        begin
            frame_out.left  = lw;
            frame_out.right = rw;
        end
        else
        begin
            frame_out.left  = mix;
            frame_out.right = '0;
        end
    end

endmodule

>>> hdl/pcm_frame_format_converter.sv
// Top level: input register, conversion logic, output register and config port.
// An accepted item passes the input register, then the output register, before m_tvalid rises.
// Throughput: 1 item per cycle while m_tready is high; both stages advance together when the output drains.
// The output register lets a new item enter while a finished result waits.
// Reset: asynchronous active low; both stages empty, all four config registers set to 1.
`include "pcm_frame_format_converter_assert.svh"

module pcm_frame_format_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // left_in[15:0], right_in[31:16]
    input  logic                          s_tlast,   // frame_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // left_out[15:0], right_out[31:16]
    output logic                          m_tlast,   // last_out
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);
    import pfc_pkg::*;

    pfc_cfg_t   cfg;
    pfc_frame_t in_frame;
    pfc_frame_t conv_frame;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    pfc_frame_t s1_frame_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pfc_frame_t out_frame_reg;
    logic       s2_ready;
    logic       s1_load;
    logic       s2_load;

    pfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfc_convert u_convert (
        .cfg       (cfg),
        .frame_in  (s1_frame_reg),
        .frame_out (conv_frame)
    );

    assign in_frame.left  = s_tdata[15:0];
    assign in_frame.right = s_tdata[31:16];
    assign in_frame.last  = s_tlast;

    assign s2_ready = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign s1_load  = s_tvalid && s_tready;
    assign s2_load  = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_ready)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_frame_reg <= in_frame;
        if (s2_load)
            out_frame_reg <= conv_frame;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_frame_reg.right, out_frame_reg.left};
    assign m_tlast  = out_frame_reg.last;

    `PFC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, s_tvalid && s_tready, s1_valid_reg)
    `PFC_ASSERT_SAME(a_full_stall_blocks, clk, rst_n, s1_valid_reg && !s2_ready, !s_tready)
    `PFC_ASSERT_NEXT(a_s1_moves_to_out, clk, rst_n, s1_valid_reg && s2_ready, m_tvalid)

endmodule
